// ----- rtl/core/fsd_pkg.sv -----
// shared types, constants and arithmetic helpers of the dither core
package fsd_pkg;

  localparam int unsigned MaxWidthDef  = 2048;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned LevelsW      = 9;
  localparam int unsigned FrameWidthW  = 12;
  localparam int unsigned FrameHeightW = 16;
  localparam int unsigned PixW         = 8;
  localparam int unsigned DivW         = 9;

  localparam logic [CfgIdxW-1:0] RegLevels      = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd2;

  localparam logic [LevelsW-1:0]      LevelsRst      = 9'd2;
  localparam logic [FrameWidthW-1:0]  FrameWidthRst  = 12'd640;
  localparam logic [FrameHeightW-1:0] FrameHeightRst = 16'd480;

  localparam logic OpPixel = 1'b0;
  localparam logic OpDrain = 1'b1;

  // diffusion weights in sixteenths
  localparam logic [2:0] WRight      = 3'd7;
  localparam logic [2:0] WBelowLeft  = 3'd3;
  localparam logic [2:0] WBelow      = 3'd5;
  localparam logic [2:0] WBelowRight = 3'd1;

  localparam logic [DivW-1:0] StepNum = 9'd256;
  localparam logic [DivW-1:0] GapNum  = 9'd255;
  localparam logic [PixW-1:0] PixMax  = 8'd255;

  typedef enum logic [1:0] {
    PK_P1    = 2'd0,
    PK_P2    = 2'd1,
    PK_DRAIN = 2'd2
  } proc_e;

  typedef enum logic [1:0] {
    DK_STEP  = 2'd0,
    DK_GAP   = 2'd1,
    DK_QUANT = 2'd2
  } div_e;

  typedef struct packed {
    logic  in_latch;
    logic  raw_wr;
    logic  load_ba;
    logic  rd;
    logic  div_start;
    div_e  div_kind;
    logic  set_der;
    logic  map;
    logic  emit;
    logic  wr2;
    logic  adv_pixel;
    logic  adv_drain;
    proc_e kind;
  } cmd_t;

  typedef struct packed {
    logic op_drain;
    logic frame_full;
    logic row_zero;
    logic col_zero;
    logic col_last;
    logic x_zero;
    logic der_ok;
    logic div_done;
    logic out_free;
  } status_t;

  // saturating add of a signed share to a pixel
  function automatic logic [PixW-1:0] add_sat(logic [PixW-1:0] a, logic signed [7:0] d);
    logic signed [9:0] s;
    s = $signed({2'b00, a}) + 10'(d);
    if (s < 0) begin
      return '0;
    end else if (s > 10'sd255) begin
      return PixMax;
    end else begin
      return s[7:0];
    end
  endfunction

  // e * k / 16, truncated toward zero
  function automatic logic signed [7:0] share(logic signed [9:0] e, logic [2:0] k);
    logic signed [13:0] t;
    logic [13:0] mag;
    logic [13:0] q;
    t = 14'(e) * $signed({11'd0, k});
    mag = (t < 0) ? 14'(-t) : 14'(t);
    q = mag >> 4;
    return (t < 0) ? 8'(-$signed(q)) : 8'(q);
  endfunction

endpackage

// ----- rtl/core/floyd_steinberg_dither_core.sv -----
// top level of the floyd-steinberg error diffusion dither core
//
// input channel (in_valid_i/in_ready_o) carries one request per pixel: op_i
// selects a new raster pixel or a drain tick after the last pixel of a frame
// output channel (out_valid_o/out_ready_i) returns quantised pixels one row
// behind the input; the final row comes out one pixel per drain tick
// configuration writes (levels, frame width, frame height) restart the frame
// a request that gives no result ends after dispatch; a processed pixel is
// read, quantised through the serial divider, whose 9 steps form the
// quantiser index, then mapped and emitted; the last pixel of a row
// processes two pixels (one when the row is one pixel wide)
// after reset or a levels write the first request also derives the
// quantiser step and gap with the same divider
// a single output register holds a finished pixel; a stalled receiver keeps
// the sequencer waiting before the next result, input is taken once done
// reset clears counters and the output valid flag; the line store is not
// cleared, each entry being written before it is read within a frame
module floyd_steinberg_dither_core #(
  parameter int unsigned MAX_WIDTH = fsd_pkg::MaxWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel requests
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [fsd_pkg::PixW-1:0]         pixel_in_i,
  // results
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fsd_pkg::PixW-1:0]         pixel_out_o,
  output logic                             last_of_run_o,
  output logic                             frame_end_o,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [fsd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fsd_pkg::CfgDataW-1:0]     cfg_data_i
);
  import fsd_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  logic [LevelsW-1:0]      levels_q, levels_eff;
  logic [FrameWidthW-1:0]  width_q;
  logic [FrameHeightW-1:0] height_q, height_eff;
  logic [WW-1:0]           width_eff;
  logic                    cfg_clear, levels_wr;
  cmd_t                    cmd;
  status_t                 st;

  // register decode; unknown index writes are dropped
  always_comb begin
    cfg_clear = 1'b0;
    levels_wr = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLevels: begin
          cfg_clear = 1'b1;
          levels_wr = 1'b1;
        end
        RegFrameWidth, RegFrameHeight: cfg_clear = 1'b1;
        default: cfg_clear = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= LevelsRst;
      width_q  <= FrameWidthRst;
      height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLevels:      levels_q <= cfg_data_i[LevelsW-1:0];
        RegFrameWidth:  width_q  <= cfg_data_i[FrameWidthW-1:0];
        RegFrameHeight: height_q <= cfg_data_i[FrameHeightW-1:0];
        default:        levels_q <= levels_q;
      endcase
    end
  end

  // out of range settings are clamped to the usable range
  always_comb begin
    if (levels_q < LevelsW'(2)) begin
      levels_eff = LevelsW'(2);
    end else if (levels_q > LevelsW'(256)) begin
      levels_eff = LevelsW'(256);
    end else begin
      levels_eff = levels_q;
    end
    if (width_q == '0) begin
      width_eff = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(width_q);
    end
    height_eff = (height_q == '0) ? FrameHeightW'(1) : height_q;
  end

  fsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  fsd_datapath #(.MaxW(MAX_WIDTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .op_i          (op_i),
    .pixel_in_i    (pixel_in_i),
    .levels_i      (levels_eff),
    .width_i       (width_eff),
    .height_i      (height_eff),
    .cfg_clear_i   (cfg_clear),
    .levels_wr_i   (levels_wr),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_out_o   (pixel_out_o),
    .last_of_run_o (last_of_run_o),
    .frame_end_o   (frame_end_o)
  );
endmodule

// ----- rtl/core/fsd_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module fsd_div #(
  parameter int unsigned W = fsd_pkg::DivW
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [W-1:0]    rem_q, quo_q, dvs_q;
  logic [W:0]      sh, diff;
  logic            ge;

  assign sh   = {rem_q, quo_q[W-1]};
  assign ge   = sh >= {1'b0, dvs_q};
  assign diff = sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CntW'(W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CntW'(1);
      done_q <= (cnt_q == CntW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[W-1:0] : sh[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

// ----- rtl/core/fsd_ctrl.sv -----
// sequencer of the dither core
module fsd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fsd_pkg::status_t st_i,
  output fsd_pkg::cmd_t    cmd_o
);
  import fsd_pkg::*;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b000000000001,
    ST_DISPATCH  = 12'b000000000010,
    ST_STEP_GO   = 12'b000000000100,
    ST_STEP_WAIT = 12'b000000001000,
    ST_GAP_GO    = 12'b000000010000,
    ST_GAP_WAIT  = 12'b000000100000,
    ST_READ      = 12'b000001000000,
    ST_OPER      = 12'b000010000000,
    ST_DIV_WAIT  = 12'b000100000000,
    ST_MAP       = 12'b001000000000,
    ST_EMIT      = 12'b010000000000,
    ST_WRITE2    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  proc_e  kind_q, kind_d;

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_latch = 1'b1;
          state_d        = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!st_i.der_ok) begin
          state_d = ST_STEP_GO;
        end else if (st_i.op_drain) begin
          if (st_i.frame_full) begin
            kind_d  = PK_DRAIN;
            state_d = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (st_i.frame_full) begin
          state_d = ST_IDLE;
        end else if (st_i.row_zero) begin
          cmd_o.raw_wr    = 1'b1;
          cmd_o.adv_pixel = 1'b1;
          state_d         = ST_IDLE;
        end else if (st_i.col_zero) begin
          cmd_o.load_ba = 1'b1;
          if (st_i.col_last) begin
            kind_d  = PK_P2;
            state_d = ST_READ;
          end else begin
            cmd_o.adv_pixel = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          kind_d  = PK_P1;
          state_d = ST_READ;
        end
      end
      ST_STEP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_kind  = DK_STEP;
        state_d         = ST_STEP_WAIT;
      end
      ST_STEP_WAIT: begin
        if (st_i.div_done) state_d = ST_GAP_GO;
      end
      ST_GAP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_kind  = DK_GAP;
        state_d         = ST_GAP_WAIT;
      end
      ST_GAP_WAIT: begin
        if (st_i.div_done) begin
          cmd_o.set_der = 1'b1;
          state_d       = ST_DISPATCH;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_OPER;
      end
      ST_OPER: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_kind  = DK_QUANT;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (st_i.div_done) state_d = ST_MAP;
      end
      ST_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          unique case (kind_q)
            PK_P1: begin
              if (st_i.col_last) begin
                kind_d  = PK_P2;
                state_d = ST_READ;
              end else begin
                cmd_o.adv_pixel = 1'b1;
                state_d         = ST_IDLE;
              end
            end
            PK_P2: begin
              if (!st_i.x_zero) begin
                state_d = ST_WRITE2;
              end else begin
                cmd_o.adv_pixel = 1'b1;
                state_d         = ST_IDLE;
              end
            end
            default: begin
              cmd_o.adv_drain = 1'b1;
              state_d         = ST_IDLE;
            end
          endcase
        end
      end
      ST_WRITE2: begin
        cmd_o.wr2       = 1'b1;
        cmd_o.adv_pixel = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= PK_P1;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> st_i.out_free)
    else $error("result loaded while output register still full");

  a_read_der: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> st_i.der_ok)
    else $error("pixel read before quantiser constants are ready");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_DISPATCH))
    else $error("accepted request not dispatched");
endmodule

// ----- rtl/core/fsd_datapath.sv -----
// line store, counters, quantiser and error diffusion arithmetic
module fsd_datapath #(
  parameter int unsigned MaxW = fsd_pkg::MaxWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fsd_pkg::cmd_t                        cmd_i,
  output fsd_pkg::status_t                     st_o,
  input  logic                                 op_i,
  input  logic [fsd_pkg::PixW-1:0]             pixel_in_i,
  input  logic [fsd_pkg::LevelsW-1:0]          levels_i,
  input  logic [$clog2(MaxW+1)-1:0]            width_i,
  input  logic [fsd_pkg::FrameHeightW-1:0]     height_i,
  input  logic                                 cfg_clear_i,
  input  logic                                 levels_wr_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [fsd_pkg::PixW-1:0]             pixel_out_o,
  output logic                                 last_of_run_o,
  output logic                                 frame_end_o
);
  import fsd_pkg::*;

  localparam int unsigned CW    = $clog2(MaxW);
  localparam int unsigned WW    = $clog2(MaxW + 1);
  localparam int unsigned Depth = 2 * MaxW;
  localparam int unsigned AW    = $clog2(Depth);

  function automatic logic [AW-1:0] slot(logic parity, logic [CW-1:0] col);
    return parity ? (AW'(MaxW) + AW'(col)) : AW'(col);
  endfunction

  logic [PixW-1:0] mem_q [Depth];

  logic                    op_q;
  logic [PixW-1:0]         pix_q;
  logic [CW-1:0]           col_q, x_q, x_sel;
  logic [FrameHeightW-1:0] row_q;
  logic                    der_ok_q;
  div_e                    div_kind_q;
  logic [PixW-1:0]         rdata_q, o_q, o_d, i_q, step_q, gap_q, n_q, ba_q, bb_q;
  logic signed [9:0]       e_q;
  logic signed [7:0]       pend7_q;
  logic signed [7:0]       s7, s3, s5, s1;
  logic [WW-1:0]           col_inc;
  logic                    col_last;
  logic                    out_valid_q, out_last_q, out_fend_q;
  logic [PixW-1:0]         out_pix_q;

  // divider
  logic            div_done;
  logic [DivW-1:0] div_q, div_a, div_b;

  // map
  logic [LevelsW-1:0] lv_m1;
  logic [PixW-1:0]    i_cl, n_d;
  logic [15:0]        prod;

  // write port
  logic            we;
  logic [AW-1:0]   waddr;
  logic [PixW-1:0] wdata;

  assign col_inc  = WW'(col_q) + WW'(1);
  assign col_last = col_inc >= width_i;
  assign x_sel    = (cmd_i.kind == PK_P1) ? (col_q - CW'(1)) : col_q;

  assign s7 = share(e_q, WRight);
  assign s3 = share(e_q, WBelowLeft);
  assign s5 = share(e_q, WBelow);
  assign s1 = share(e_q, WBelowRight);

  assign o_d = add_sat(rdata_q, (x_q != '0) ? pend7_q : 8'sd0);

  always_comb begin
    case (cmd_i.div_kind)
      DK_STEP: begin
        div_a = StepNum;
        div_b = levels_i;
      end
      DK_GAP: begin
        div_a = GapNum;
        div_b = levels_i - LevelsW'(1);
      end
      default: begin
        div_a = {1'b0, o_d};
        div_b = {1'b0, step_q};
      end
    endcase
  end

  fsd_div #(.W(DivW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign lv_m1 = levels_i - LevelsW'(1);
  assign i_cl  = ({1'b0, i_q} > lv_m1) ? lv_m1[PixW-1:0] : i_q;
  assign prod  = i_cl * gap_q;
  assign n_d   = (o_q == '0 || o_q == PixMax) ? o_q : prod[PixW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = slot(row_q[0], col_q);
    wdata = pix_q;
    if (cmd_i.raw_wr) begin
      we = 1'b1;
    end else if (cmd_i.emit && cmd_i.kind == PK_P1 && x_q != '0) begin
      we    = 1'b1;
      waddr = slot(row_q[0], x_q - CW'(1));
      wdata = add_sat(bb_q, s3);
    end else if (cmd_i.emit && cmd_i.kind == PK_P2) begin
      we    = 1'b1;
      waddr = slot(row_q[0], x_q);
      wdata = add_sat(ba_q, s5);
    end else if (cmd_i.wr2) begin
      we    = 1'b1;
      waddr = slot(row_q[0], x_q - CW'(1));
      wdata = add_sat(bb_q, s3);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (cmd_i.rd) rdata_q <= mem_q[slot(~row_q[0], x_sel)];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      der_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_clear_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (cmd_i.adv_pixel) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= row_q + FrameHeightW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end else if (cmd_i.adv_drain) begin
        if (col_last) begin
          col_q <= '0;
          row_q <= '0;
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (levels_wr_i) begin
        der_ok_q <= 1'b0;
      end else if (cmd_i.set_der) begin
        der_ok_q <= 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_latch) begin
      op_q  <= op_i;
      pix_q <= pixel_in_i;
    end
    if (cmd_i.rd) x_q <= x_sel;
    if (cmd_i.div_start) div_kind_q <= cmd_i.div_kind;
    if (cmd_i.div_start && cmd_i.div_kind == DK_QUANT) o_q <= o_d;
    if (div_done) begin
      case (div_kind_q)
        DK_STEP: step_q <= div_q[PixW-1:0];
        DK_GAP:  gap_q  <= div_q[PixW-1:0];
        default: i_q    <= div_q[PixW-1:0];
      endcase
    end
    if (cmd_i.map) begin
      n_q <= n_d;
      e_q <= $signed({2'b00, o_q}) - $signed({2'b00, n_d});
    end
    if (cmd_i.load_ba) ba_q <= pix_q;
    if (cmd_i.emit) begin
      pend7_q    <= s7;
      out_pix_q  <= n_q;
      out_last_q <= (cmd_i.kind != PK_P1) || !col_last;
      out_fend_q <= (cmd_i.kind == PK_DRAIN) && col_last;
      if (cmd_i.kind == PK_P1) begin
        bb_q <= add_sat(ba_q, s5);
        ba_q <= add_sat(pix_q, s1);
      end
    end
  end

  assign st_o.op_drain   = (op_q == OpDrain);
  assign st_o.frame_full = (row_q >= height_i);
  assign st_o.row_zero   = (row_q == '0);
  assign st_o.col_zero   = (col_q == '0);
  assign st_o.col_last   = col_last;
  assign st_o.x_zero     = (x_q == '0);
  assign st_o.der_ok     = der_ok_q;
  assign st_o.div_done   = div_done;
  assign st_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pixel_out_o   = out_pix_q;
  assign last_of_run_o = out_last_q;
  assign frame_end_o   = out_fend_q;
endmodule

// ----- bench/floyd_steinberg_dither_core_test.sv -----
// self-checking bench of the dither core: own error-diffusion predictor, random stalls
module floyd_steinberg_dither_core_test;
  import fsd_pkg::*;

  localparam int unsigned StoreW = 2048;

  // one quantised pixel as the block should return it
  typedef struct {
    logic [PixW-1:0] pix;
    logic            last;
    logic            fend;
  } dither_res_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                op;
  logic [PixW-1:0]     pixel_in;
  logic                out_valid;
  logic                out_ready;
  logic [PixW-1:0]     pixel_out;
  logic                last_of_run;
  logic                frame_end;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  floyd_steinberg_dither_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op),
    .pixel_in_i   (pixel_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .pixel_out_o  (pixel_out),
    .last_of_run_o(last_of_run),
    .frame_end_o  (frame_end),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  // predictor state
  logic [PixW-1:0]         line_mem [2*StoreW];
  logic [LevelsW-1:0]      lvl_reg;
  logic [FrameWidthW-1:0]  fw_reg;
  logic [FrameHeightW-1:0] fh_reg;
  int unsigned             col_in, row_in, col_out;

  dither_res_t pending_pixels[$];
  int          n_errors;
  int          n_requests;
  int          n_results;
  int          n_frames;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_len;
  int          hold_cnt;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * 4_000_000);
    $display("FAIL floyd_steinberg_dither_core");
    $finish;
  end

  function automatic int unsigned eff_levels();
    if (lvl_reg < 2) return 2;
    if (lvl_reg > 256) return 256;
    return lvl_reg;
  endfunction

  function automatic int unsigned eff_width();
    if (fw_reg == 0) return 1;
    if (fw_reg > StoreW) return StoreW;
    return fw_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (fh_reg == 0) ? 1 : fh_reg;
  endfunction

  function automatic int unsigned mem_slot(int unsigned row, int unsigned col);
    return (row & 1) * StoreW + (col % StoreW);
  endfunction

  function automatic int unsigned quantise(int unsigned o);
    int unsigned l, stp, gap, idx;
    if (o == 0 || o == 255) return o;
    l   = eff_levels();
    stp = 256 / l;
    gap = 255 / (l - 1);
    idx = o / stp;
    if (idx > l - 1) idx = l - 1;
    return idx * gap;
  endfunction

  task automatic spread(int unsigned idx, int delta);
    int s;
    s = int'(line_mem[idx]) + delta;
    line_mem[idx] = (s < 0) ? 8'd0 : ((s > 255) ? 8'd255 : 8'(s));
  endtask

  // quantise one stored pixel and push its error onto the neighbours
  task automatic dither_pixel(int unsigned x, int unsigned y, bit below,
                              output logic [PixW-1:0] q);
    int unsigned o, n;
    int          e;
    bit          right;
    o     = line_mem[mem_slot(y, x)];
    n     = quantise(o);
    e     = int'(o) - int'(n);
    right = (x + 1) < eff_width();
    line_mem[mem_slot(y, x)] = 8'(n);
    if (right) spread(mem_slot(y, x + 1), (e * 7) / 16);
    if (below) begin
      if (x > 0) spread(mem_slot(y + 1, x - 1), (e * 3) / 16);
      spread(mem_slot(y + 1, x), (e * 5) / 16);
      if (right) spread(mem_slot(y + 1, x + 1), e / 16);
    end
    q = 8'(n);
  endtask

  // work out the results of one accepted request
  task automatic predict_request(logic req_op, logic [PixW-1:0] req_pix);
    int unsigned w, h, cnt, x;
    logic [PixW-1:0] q [2];
    dither_res_t r;
    bit fend;
    w   = eff_width();
    h   = eff_height();
    cnt = 0;
    if (req_op == OpPixel) begin
      if (row_in >= h) return;
      line_mem[mem_slot(row_in, col_in)] = req_pix;
      if (row_in >= 1) begin
        if (col_in >= 1) begin
          dither_pixel(col_in - 1, row_in - 1, 1'b1, q[cnt]);
          cnt++;
        end
        if (col_in + 1 >= w) begin
          dither_pixel(w - 1, row_in - 1, 1'b1, q[cnt]);
          cnt++;
        end
      end
      if (col_in + 1 >= w) begin
        col_in = 0;
        row_in++;
      end else begin
        col_in++;
      end
      if (cnt > 0) col_out = (col_in != 0) ? col_in - 1 : 0;
      for (int k = 0; k < cnt; k++) begin
        r.pix  = q[k];
        r.last = (k == cnt - 1);
        r.fend = 1'b0;
        pending_pixels.push_back(r);
      end
    end else begin
      if (row_in < h) return;
      x    = (col_out < w) ? col_out : w - 1;
      fend = (x + 1) >= w;
      dither_pixel(x, h - 1, 1'b0, q[0]);
      r.pix  = q[0];
      r.last = 1'b1;
      r.fend = fend;
      pending_pixels.push_back(r);
      if (fend) begin
        col_in  = 0;
        row_in  = 0;
        col_out = 0;
        n_frames++;
      end else begin
        col_out = x + 1;
      end
    end
  endtask

  // one register write, predictor updated alongside
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegLevels:      lvl_reg = data[LevelsW-1:0];
      RegFrameWidth:  fw_reg  = data[FrameWidthW-1:0];
      RegFrameHeight: fh_reg  = data[FrameHeightW-1:0];
      default: ;
    endcase
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    @(posedge clk);
  endtask

  task automatic set_frame(int unsigned lv, int unsigned w, int unsigned h);
    write_reg(RegLevels, CfgDataW'(lv));
    write_reg(RegFrameWidth, CfgDataW'(w));
    write_reg(RegFrameHeight, CfgDataW'(h));
  endtask

  // offer one request; valid stays high afterwards unless the next call idles
  task automatic send_request(logic req_op, logic [PixW-1:0] req_pix);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= req_op;
    pixel_in <= req_pix;
    // ready seen at the falling edge means acceptance at the next rising edge
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    predict_request(req_op, req_pix);
    n_requests++;
    @(posedge clk);
  endtask

  // block quiet: nothing outstanding and the sequencer finished
  task automatic wait_idle();
    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [PixW-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(1, 6));
      3:       return 8'($urandom_range(249, 254));
      default: return 8'($urandom);
    endcase
  endfunction

  // whole frame, with optional ignored requests mixed in
  task automatic run_frame(int unsigned w, int unsigned h, bit noise);
    int unsigned ew, eh;
    ew = (w == 0) ? 1 : ((w > StoreW) ? StoreW : w);
    eh = (h == 0) ? 1 : h;
    for (int unsigned i = 0; i < ew * eh; i++) begin
      if (noise && $urandom_range(9) == 0) send_request(OpDrain, 8'($urandom));
      send_request(OpPixel, rand_pixel());
    end
    if (noise) begin
      repeat ($urandom_range(1, 2)) send_request(OpPixel, 8'($urandom));
    end
    for (int unsigned i = 0; i < ew; i++) send_request(OpDrain, 8'($urandom));
  endtask

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result check, at the falling edge ahead of the accepting rising edge
  always @(negedge clk) begin
    dither_res_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result pixel_out=%0d", pixel_out);
        n_errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_out !== want.pix) begin
          $error("pixel_out expected %0d actual %0d", want.pix, pixel_out);
          n_errors++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run expected %0d actual %0d", want.last, last_of_run);
          n_errors++;
        end
        if (frame_end !== want.fend) begin
          $error("frame_end expected %0d actual %0d", want.fend, frame_end);
          n_errors++;
        end
      end
    end
  end

  // small frames, edge cases of the sequencing
  task automatic test_directed();
    set_frame(2, 4, 3);
    send_request(OpPixel, 8'd0);
    send_request(OpPixel, 8'd255);
    send_request(OpDrain, 8'd0);  // drain before the frame is in: ignored
    send_request(OpPixel, 8'd128);
    send_request(OpPixel, 8'd1);
    send_request(OpPixel, 8'd254);
    send_request(OpPixel, 8'd127);
    send_request(OpPixel, 8'd200);
    send_request(OpPixel, 8'd60);
    send_request(OpPixel, 8'd90);
    send_request(OpPixel, 8'd170);
    send_request(OpPixel, 8'd33);
    send_request(OpPixel, 8'd240);
    send_request(OpPixel, 8'd77);  // frame already in: ignored
    repeat (4) send_request(OpDrain, 8'hff);
    wait_idle();
    set_frame(256, 1, 1);
    send_request(OpPixel, 8'd129);
    send_request(OpDrain, 8'd0);
    wait_idle();
  endtask

  // register extremes and out-of-range values
  task automatic test_register_extremes();
    set_frame(0, 0, 0);
    run_frame(1, 1, 0);
    wait_idle();
    set_frame(1, 3, 2);
    run_frame(3, 2, 0);
    wait_idle();
    set_frame(16'hffff, 2, 2);
    run_frame(2, 2, 0);
    wait_idle();
    set_frame(3, 5, 16'hffff);
    repeat (12) send_request(OpPixel, rand_pixel());
    wait_idle();
    set_frame(511, 16'hffff, 2);  // width above the store: first row stays open
    repeat (40) send_request(OpPixel, rand_pixel());
    wait_idle();
    set_frame(256, 24, 2);
    run_frame(24, 2, 0);
    wait_idle();
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_output_stall();
    set_frame(5, 6, 6);
    hold_len = 500;
    run_frame(6, 6, 0);
    wait_idle();
  endtask

  task automatic random_frames(int unsigned budget);
    int unsigned start, w, h, lv;
    start = n_requests;
    while (n_requests - start < budget) begin
      case ($urandom_range(4))
        0:       lv = 2;
        1:       lv = 256;
        2:       lv = $urandom_range(0, 511);
        default: lv = $urandom_range(3, 40);
      endcase
      w = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 9);
      h = $urandom_range(1, 5);
      set_frame(lv, w, h);
      if ($urandom_range(9) == 0) begin
        // broken frame, cut short by the next configuration
        repeat ($urandom_range(1, w * h)) send_request(OpPixel, rand_pixel());
      end else begin
        run_frame(w, h, $urandom_range(3) == 0);
      end
      wait_idle();
    end
  endtask

  task automatic test_random();
    send_idle_pct = 28;
    recv_idle_pct = 71;
    random_frames(260);
    send_idle_pct = 71;
    recv_idle_pct = 28;
    random_frames(260);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_frames(260);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    op            = OpPixel;
    pixel_in      = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = RegLevels;
    cfg_data      = '0;
    n_errors      = 0;
    n_requests    = 0;
    n_results     = 0;
    n_frames      = 0;
    hold_len      = 0;
    hold_cnt      = 0;
    send_idle_pct = 28;
    recv_idle_pct = 71;
    lvl_reg       = LevelsRst;
    fw_reg        = FrameWidthRst;
    fh_reg        = FrameHeightRst;
    col_in        = 0;
    row_in        = 0;
    col_out       = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_output_stall();
    test_random();
    wait_idle();

    $display("covered %0d requests, %0d results checked, %0d frames drained",
             n_requests, n_results, n_frames);
    $display("levels, width and height extremes, ignored requests and output stalls");
    if (n_errors == 0 && pending_pixels.size() == 0) begin
      $display("PASS floyd_steinberg_dither_core");
    end else begin
      $display("FAIL floyd_steinberg_dither_core");
    end
    $finish;
  end

endmodule
